// File: design/kt_pkg.sv
// Shared types, constants and keyword tables of the keyword tokenizer.
package kt_pkg;

  localparam int NumKw      = 14;
  localparam int KwMaxLen   = 13;
  localparam int LenBits    = 16;
  localparam int OutPosBits = 16;
  localparam int KindBits   = 5;
  localparam int Slots      = 4;
  localparam int QueueDepth = 4;
  localparam int PositionBitsDefault = 16;

  typedef logic [KindBits-1:0] kind_t;

  localparam kind_t KindIdent  = 5'd0;
  localparam kind_t KindString = 5'd15;
  localparam kind_t KindInt    = 5'd16;
  localparam kind_t KindLbrace = 5'd17;
  localparam kind_t KindRbrace = 5'd18;
  localparam kind_t KindColon  = 5'd19;
  localparam kind_t KindPipe   = 5'd20;
  localparam kind_t KindSemi   = 5'd21;
  localparam kind_t KindEnd    = 5'd22;

  typedef enum logic [3:0] {
    ModeIdle = 4'b0001,
    ModeWord = 4'b0010,
    ModeInt  = 4'b0100,
    ModeStr  = 4'b1000
  } scan_mode_e;

  localparam logic [7:0] ChQuote  = 8'h22;
  localparam logic [7:0] ChLbrace = 8'h7B;
  localparam logic [7:0] ChRbrace = 8'h7D;
  localparam logic [7:0] ChColon  = 8'h3A;
  localparam logic [7:0] ChPipe   = 8'h7C;
  localparam logic [7:0] ChSemi   = 8'h3B;
  localparam logic [7:0] ChUnder  = 8'h5F;

  // Keyword text, right-justified: first character sits in the highest used byte.
  localparam logic [KwMaxLen*8-1:0] KwText [NumKw] = '{
    "ClientProfile", "assign", "to", "Monday", "Tuesday", "Wednesday",
    "Thursday", "Friday", "Saturday", "Sunday", "exercise", "sets",
    "rest", "showPlans"
  };
  localparam logic [3:0] KwLen [NumKw] = '{
    4'd13, 4'd6, 4'd2, 4'd6, 4'd7, 4'd9, 4'd8, 4'd6, 4'd8, 4'd6, 4'd8, 4'd4,
    4'd4, 4'd9
  };

  typedef struct packed {
    kind_t                kind;
    logic [OutPosBits-1:0] start;
    logic [LenBits-1:0]    length;
  } token_t;

  typedef struct packed {
    logic [Slots-1:0]   valid;
    token_t [Slots-1:0] tok;
  } bundle_t;

  function automatic logic [LenBits-1:0] sat_inc(input logic [LenBits-1:0] v);
    sat_inc = v + LenBits'(v != '1);
  endfunction

  // Drop every keyword that ends before this offset or differs from c there.
  function automatic logic [NumKw-1:0] kw_match(input logic [NumKw-1:0]   mask,
                                                input logic [LenBits-1:0] len,
                                                input logic [7:0]         c);
    logic [NumKw-1:0] m;
    logic [3:0]       i;
    m = mask;
    i = len[3:0];
    for (int k = 0; k < NumKw; k++) begin
      if (len < LenBits'(KwLen[k])) begin
        if (KwText[k][(int'(KwLen[k]) - 1 - int'(i)) * 8 +: 8] != c) m[k] = 1'b0;
      end else begin
        m[k] = 1'b0;
      end
    end
    kw_match = m;
  endfunction

  // First surviving keyword of full length wins, otherwise identifier.
  function automatic kind_t kw_kind(input logic [NumKw-1:0]   mask,
                                    input logic [LenBits-1:0] len);
    kind_t kind;
    kind = KindIdent;
    for (int k = NumKw - 1; k >= 0; k--) begin
      if (mask[k] && len == LenBits'(KwLen[k])) kind = kind_t'(k + 1);
    end
    kw_kind = kind;
  endfunction

endpackage

// File: design/kt_front.sv
// Front scanner: classifies each byte and builds the bundle of tokens it closes.
module kt_front import kt_pkg::*; #(
  parameter int PositionBits = PositionBitsDefault
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  logic [7:0]    char_byte_i,
  input  logic          end_of_input_i,
  input  logic          full_i,
  output logic          push_o,
  output bundle_t       push_data_o
);

  localparam int PosW = PositionBits < OutPosBits ? PositionBits : OutPosBits;

  scan_mode_e         mode_q, mode_d;
  logic [NumKw-1:0]   mask_q, mask_d;
  logic [LenBits-1:0] len_q, len_d;
  logic [PosW-1:0]    begin_q, begin_d;
  logic [PosW-1:0]    pos_q, pos_d;

  logic    acc;
  logic    taken;
  logic    fin;
  bundle_t bnd;

  function automatic logic is_alpha(input logic [7:0] c);
    is_alpha = (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    is_digit = c >= 8'h30 && c <= 8'h39;
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    is_space = c == 8'h20 || (c >= 8'h09 && c <= 8'h0D);
  endfunction

  assign in_stall_o  = full_i;
  assign acc         = in_valid_i && !full_i;
  assign push_o      = acc && (|bnd.valid);
  assign push_data_o = bnd;
  assign fin         = (char_byte_i == 8'h00) || end_of_input_i;

  always_comb begin
    mode_d  = mode_q;
    mask_d  = mask_q;
    len_d   = len_q;
    begin_d = begin_q;
    pos_d   = pos_q;
    bnd     = '0;
    taken   = 1'b0;

    if (char_byte_i != 8'h00) begin
      case (mode_q)
        ModeWord: begin
          if (is_alpha(char_byte_i) || is_digit(char_byte_i) || char_byte_i == ChUnder) begin
            mask_d = kw_match(mask_q, len_q, char_byte_i);
            len_d  = sat_inc(len_q);
            taken  = 1'b1;
          end else begin
            bnd.valid[0] = 1'b1;
            bnd.tok[0]   = '{kind: kw_kind(mask_q, len_q), start: OutPosBits'(begin_q),
                             length: len_q};
            mode_d       = ModeIdle;
          end
        end
        ModeInt: begin
          if (is_digit(char_byte_i)) begin
            len_d = sat_inc(len_q);
            taken = 1'b1;
          end else begin
            bnd.valid[0] = 1'b1;
            bnd.tok[0]   = '{kind: KindInt, start: OutPosBits'(begin_q), length: len_q};
            mode_d       = ModeIdle;
          end
        end
        ModeStr: begin
          taken = 1'b1;
          if (char_byte_i == ChQuote) begin
            bnd.valid[1] = 1'b1;
            bnd.tok[1]   = '{kind: KindString, start: OutPosBits'(begin_q), length: len_q};
            mode_d       = ModeIdle;
          end else begin
            len_d = sat_inc(len_q);
          end
        end
        default: ;
      endcase

      // A byte that closed a word or number is handled again from idle.
      if (!taken && !is_space(char_byte_i)) begin
        if (is_alpha(char_byte_i) || char_byte_i == ChUnder) begin
          mode_d  = ModeWord;
          begin_d = pos_q;
          mask_d  = kw_match('1, '0, char_byte_i);
          len_d   = LenBits'(1);
        end else if (is_digit(char_byte_i)) begin
          mode_d  = ModeInt;
          begin_d = pos_q;
          len_d   = LenBits'(1);
        end else if (char_byte_i == ChQuote) begin
          mode_d  = ModeStr;
          begin_d = pos_q + PosW'(pos_q != '1);
          len_d   = '0;
        end else begin
          bnd.tok[1] = '{kind: KindLbrace, start: OutPosBits'(pos_q), length: LenBits'(1)};
          case (char_byte_i)
            ChLbrace: begin bnd.valid[1] = 1'b1; bnd.tok[1].kind = KindLbrace; end
            ChRbrace: begin bnd.valid[1] = 1'b1; bnd.tok[1].kind = KindRbrace; end
            ChColon:  begin bnd.valid[1] = 1'b1; bnd.tok[1].kind = KindColon;  end
            ChPipe:   begin bnd.valid[1] = 1'b1; bnd.tok[1].kind = KindPipe;   end
            ChSemi:   begin bnd.valid[1] = 1'b1; bnd.tok[1].kind = KindSemi;   end
            default:  ;
          endcase
        end
      end

      pos_d = pos_q + PosW'(pos_q != '1);
    end

    // Flush the open word or number, append the end token, restart the text.
    if (fin) begin
      if (mode_d == ModeWord) begin
        bnd.valid[2] = 1'b1;
        bnd.tok[2]   = '{kind: kw_kind(mask_d, len_d), start: OutPosBits'(begin_d),
                         length: len_d};
      end else if (mode_d == ModeInt) begin
        bnd.valid[2] = 1'b1;
        bnd.tok[2]   = '{kind: KindInt, start: OutPosBits'(begin_d), length: len_d};
      end
      bnd.valid[3] = 1'b1;
      bnd.tok[3]   = '{kind: KindEnd, start: OutPosBits'(pos_d), length: '0};
      mode_d  = ModeIdle;
      mask_d  = '1;
      len_d   = '0;
      begin_d = '0;
      pos_d   = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= ModeIdle;
      mask_q  <= '1;
      len_q   <= '0;
      begin_q <= '0;
      pos_q   <= '0;
    end else if (acc) begin
      mode_q  <= mode_d;
      mask_q  <= mask_d;
      len_q   <= len_d;
      begin_q <= begin_d;
      pos_q   <= pos_d;
    end
  end

endmodule

// File: design/kt_queue.sv
// Small bundle queue between the scanner and the token serializer.
module kt_queue import kt_pkg::*; #(
  parameter int Depth = QueueDepth
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  bundle_t push_data_i,
  output logic    full_o,
  output logic    valid_o,
  output bundle_t data_o,
  input  logic    pop_i
);

  localparam int PtrW = Depth > 1 ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  bundle_t           mem_q [Depth];
  logic [PtrW-1:0]   wr_q, rd_q;
  logic [CntW-1:0]   cnt_q;

  function automatic logic [PtrW-1:0] wrap_inc(input logic [PtrW-1:0] p);
    wrap_inc = (p == PtrW'(Depth - 1)) ? '0 : p + PtrW'(1);
  endfunction

  assign full_o  = cnt_q == CntW'(Depth);
  assign valid_o = cnt_q != '0;
  assign data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= push_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= wrap_inc(wr_q);
      if (pop_i)  rd_q <= wrap_inc(rd_q);
      case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + CntW'(1);
        2'b01:   cnt_q <= cnt_q - CntW'(1);
        default: ;
      endcase
    end
  end

endmodule

// File: design/kt_back.sv
// Token serializer: sends the tokens of one bundle, one per transaction.
module kt_back import kt_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  q_valid_i,
  input  bundle_t               q_data_i,
  output logic                  q_pop_o,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [KindBits-1:0]   token_kind_o,
  output logic [OutPosBits-1:0] token_start_o,
  output logic [LenBits-1:0]    token_length_o,
  output logic                  last_result_o
);

  logic [Slots-1:0]   rem_q;
  token_t [Slots-1:0] tok_q;

  logic [Slots-1:0] lowest;
  logic [Slots-1:0] rem_after;
  logic             out_acc;
  logic             take;
  token_t           sel;

  assign lowest    = rem_q & (~rem_q + Slots'(1));
  assign rem_after = rem_q & ~lowest;

  always_comb begin
    sel = '0;
    for (int s = 0; s < Slots; s++) begin
      if (lowest[s]) sel = tok_q[s];
    end
  end

  assign out_valid_o    = |rem_q;
  assign last_result_o  = rem_after == '0;
  assign token_kind_o   = sel.kind;
  assign token_start_o  = sel.start;
  assign token_length_o = sel.length;

  assign out_acc = out_valid_o && !out_stall_i;
  // Load the next bundle when empty or while the last token is accepted.
  assign take    = q_valid_i && (!out_valid_o || (out_acc && last_result_o));
  assign q_pop_o = take;

  always_ff @(posedge clk_i) begin
    if (take) tok_q <= q_data_i.tok;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q <= '0;
    end else if (take) begin
      rem_q <= q_data_i.valid;
    end else if (out_acc) begin
      rem_q <= rem_after;
    end
  end

endmodule

// File: design/keyword_tokenizer.sv
// Keyword tokenizer: top level joining scanner, bundle queue and serializer.
//
// Takes one text byte per cycle and returns tokens as kind, start offset and
// length. Every byte is accepted whenever the four-entry bundle queue has
// room. The serializer sends one token per cycle unless the output stalls,
// so a byte that closes two or three tokens (a token ended by a symbol, or
// an open token at end of input) holds the output for each in turn, and the
// queue lets the scanner keep taking bytes meanwhile. Sustained rate is one
// byte per cycle without output stalls as long as tokens average no more
// than one per byte. Offsets saturate at 2**POSITION_BITS-1 (at most 65535);
// lengths saturate at 65535.
module keyword_tokenizer import kt_pkg::*; #(
  parameter int POSITION_BITS = PositionBitsDefault
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [7:0]            char_byte_i,
  input  logic                  end_of_input_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [KindBits-1:0]   token_kind_o,
  output logic [OutPosBits-1:0] token_start_o,
  output logic [LenBits-1:0]    token_length_o,
  output logic                  last_result_o
);

  logic    q_push;
  logic    q_full;
  logic    q_valid;
  logic    q_pop;
  bundle_t q_wdata;
  bundle_t q_rdata;

  kt_front #(
    .PositionBits(POSITION_BITS)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .char_byte_i   (char_byte_i),
    .end_of_input_i(end_of_input_i),
    .full_i        (q_full),
    .push_o        (q_push),
    .push_data_o   (q_wdata)
  );

  kt_queue #(
    .Depth(QueueDepth)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (q_push),
    .push_data_i(q_wdata),
    .full_o     (q_full),
    .valid_o    (q_valid),
    .data_o     (q_rdata),
    .pop_i      (q_pop)
  );

  kt_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_valid_i     (q_valid),
    .q_data_i      (q_rdata),
    .q_pop_o       (q_pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .token_kind_o  (token_kind_o),
    .token_start_o (token_start_o),
    .token_length_o(token_length_o),
    .last_result_o (last_result_o)
  );

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_push |-> !q_full)
    else $error("bundle queue written while full");

  a_bundle_continues: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !last_result_o |=> out_valid_o)
    else $error("bundle ended without a last token");

  a_end_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && token_kind_o == KindEnd |-> last_result_o)
    else $error("end token not marked last");

  a_pop_when_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> q_valid)
    else $error("bundle queue read while empty");
`endif

endmodule
